// ===== design/arsc_pkg.sv =====
// Shared types and constants for the adaptive reflective sensor classifier.
// Used by every module of the block; depends on nothing else.
package arsc_pkg;

   // Field widths fixed by the interface.
   localparam int READING_W = 10;
   localparam int LEVEL_W   = 11;
   localparam int CFG_W     = 11;
   localparam int TRACK_W   = 16;
   localparam int WINDOW_W  = 18;

   // Tracker values after reset and after a clear command.
   localparam logic signed [TRACK_W-1:0] TRACK_MAX_RESET = -16'sd32760;
   localparam logic signed [TRACK_W-1:0] TRACK_MIN_RESET = 16'sd32760;

   // Command codes carried in tuser.
   localparam logic CMD_ROUND = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      REG_MAX_DISTANCE     = 2'd0,
      REG_MIN_DISTANCE     = 2'd1,
      REG_HOME_DEFAULT     = 2'd2,
      REG_POSITION_DEFAULT = 2'd3
   } csr_index_type;

   // Control word that travels with each pipeline stage.
   typedef struct packed {
      logic valid;
      logic clear;
   } stage_ctl_type;

endpackage

// ===== design/arsc_front.sv =====
// Input register and per-channel round accumulators of the sensor classifier.
// Depends on arsc_pkg.
module arsc_front #(
   parameter int SAMPLES = 8,
   parameter int SUM_W   = 14,
   parameter int CNT_W   = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic                                 command,
   input  logic [arsc_pkg::READING_W-1:0]       home_bright,
   input  logic [arsc_pkg::READING_W-1:0]       home_dark,
   input  logic [arsc_pkg::READING_W-1:0]       position_bright,
   input  logic [arsc_pkg::READING_W-1:0]       position_dark,
   output arsc_pkg::stage_ctl_type              out_ctl,
   input  logic                                 out_ready,
   output logic signed [SUM_W-1:0]              home_total,
   output logic signed [SUM_W-1:0]              position_total
);
   import arsc_pkg::*;

   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_cmd_ff;
   logic [READING_W-1:0]        s1_hb_ff, s1_hd_ff, s1_pb_ff, s1_pd_ff;
   logic signed [SUM_W-1:0]     home_sum_ff, home_sum_in;
   logic signed [SUM_W-1:0]     position_sum_ff, position_sum_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   stage_ctl_type               s2_ctl_ff, s2_ctl_in;
   logic signed [SUM_W-1:0]     home_total_ff, home_total_in;
   logic signed [SUM_W-1:0]     position_total_ff, position_total_in;
   logic signed [LEVEL_W-1:0]   home_diff, position_diff;
   logic signed [SUM_W-1:0]     home_next, position_next;
   logic                        s2_free, s1_go, last_round;

   assign s2_free  = !s2_ctl_ff.valid || out_ready;
   assign s1_go    = s1_valid_ff && s2_free;
   assign in_ready = !s1_valid_ff || s1_go;

   assign home_diff     = $signed({1'b0, s1_hd_ff}) - $signed({1'b0, s1_hb_ff});
   assign position_diff = $signed({1'b0, s1_pd_ff}) - $signed({1'b0, s1_pb_ff});
   assign home_next     = home_sum_ff + SUM_W'(home_diff);
   assign position_next = position_sum_ff + SUM_W'(position_diff);
   assign last_round    = (count_ff == CNT_W'(SAMPLES - 1));

   always_comb begin
      s1_valid_in       = in_valid ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      home_sum_in       = home_sum_ff;
      position_sum_in   = position_sum_ff;
      count_in          = count_ff;
      s2_ctl_in         = s2_ctl_ff;
      home_total_in     = home_total_ff;
      position_total_in = position_total_ff;
      if (in_valid && !in_ready) begin
         s1_valid_in = 1'b1;
      end
      if (s1_go) begin
         if (s1_cmd_ff == CMD_CLEAR) begin
            // A clear only resets the trackers; partial sums carry on.
            s2_ctl_in.valid = 1'b1;
            s2_ctl_in.clear = 1'b1;
         end else if (last_round) begin
            s2_ctl_in.valid   = 1'b1;
            s2_ctl_in.clear   = 1'b0;
            home_total_in     = home_next;
            position_total_in = position_next;
            home_sum_in       = '0;
            position_sum_in   = '0;
            count_in          = '0;
         end else begin
            s2_ctl_in.valid = 1'b0;
            home_sum_in     = home_next;
            position_sum_in = position_next;
            count_in        = count_ff + CNT_W'(1);
         end
      end else if (out_ready) begin
         s2_ctl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_ctl_ff       <= '0;
         home_sum_ff     <= '0;
         position_sum_ff <= '0;
         count_ff        <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         s2_ctl_ff       <= s2_ctl_in;
         home_sum_ff     <= home_sum_in;
         position_sum_ff <= position_sum_in;
         count_ff        <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_cmd_ff <= command;
         s1_hb_ff  <= home_bright;
         s1_hd_ff  <= home_dark;
         s1_pb_ff  <= position_bright;
         s1_pd_ff  <= position_dark;
      end
      home_total_ff     <= home_total_in;
      position_total_ff <= position_total_in;
   end

   assign out_ctl        = s2_ctl_ff;
   assign home_total     = home_total_ff;
   assign position_total = position_total_ff;

   // The round counter wraps at the block length and never reaches it.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SAMPLES - 1))
      else $error("round counter beyond block length");

endmodule

// ===== design/arsc_divide.sv =====
// Divides both block sums by SAMPLES, truncating toward zero, with a
// reciprocal multiply. Registered output stage. Depends on arsc_pkg.
module arsc_divide #(
   parameter int SAMPLES = 8,
   parameter int SUM_W   = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  arsc_pkg::stage_ctl_type              in_ctl,
   output logic                                 in_ready,
   input  logic signed [SUM_W-1:0]              home_total,
   input  logic signed [SUM_W-1:0]              position_total,
   output arsc_pkg::stage_ctl_type              out_ctl,
   input  logic                                 out_ready,
   output logic signed [arsc_pkg::LEVEL_W-1:0]  home_level,
   output logic signed [arsc_pkg::LEVEL_W-1:0]  position_level
);
   import arsc_pkg::*;

   localparam int LOG_S   = $clog2(SAMPLES);
   localparam int MAG_W   = SUM_W - 1;
   localparam int SHIFT   = MAG_W + LOG_S;
   localparam int RECIP_W = MAG_W + 1;
   localparam int PROD_W  = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

   stage_ctl_type              s3_ctl_ff, s3_ctl_in;
   logic signed [LEVEL_W-1:0]  home_level_ff, position_level_ff;

   // The magnitude is divided exactly by the rounded-up reciprocal; the sign
   // is put back afterwards, which gives truncation toward zero.
   function automatic logic signed [LEVEL_W-1:0] average(
      input logic signed [SUM_W-1:0] total);
      logic [SUM_W-1:0]       neg_total;
      logic [MAG_W-1:0]       mag;
      logic [PROD_W-1:0]      prod;
      logic [LEVEL_W-2:0]     quot;
      logic signed [LEVEL_W-1:0] pos;
      neg_total = -total;
      mag  = total[SUM_W-1] ? neg_total[MAG_W-1:0] : total[MAG_W-1:0];
      prod = PROD_W'(mag) * PROD_W'(RECIP);
      quot = prod[SHIFT +: (LEVEL_W - 1)];
      pos  = $signed({1'b0, quot});
      return total[SUM_W-1] ? -pos : pos;
   endfunction

   assign in_ready = !s3_ctl_ff.valid || out_ready;

   always_comb begin
      s3_ctl_in = s3_ctl_ff;
      if (in_ready) begin
         s3_ctl_in = in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff <= '0;
      end else begin
         s3_ctl_ff <= s3_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_ctl.valid && !in_ctl.clear) begin
         home_level_ff     <= average(home_total);
         position_level_ff <= average(position_total);
      end
   end

   assign out_ctl        = s3_ctl_ff;
   assign home_level     = home_level_ff;
   assign position_level = position_level_ff;

   // An average of ten-bit differences never reaches the most negative code.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (s3_ctl_ff.valid && !s3_ctl_ff.clear) |->
         (home_level_ff != -11'sd1024 && position_level_ff != -11'sd1024))
      else $error("averaged level out of range");

endmodule

// ===== design/arsc_track.sv =====
// Running max/min tracker, midpoint threshold and validity window for one
// sensor channel. Depends on arsc_pkg.
module arsc_track (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 update,
   input  logic                                 clear,
   input  logic signed [arsc_pkg::LEVEL_W-1:0]  level,
   input  logic [arsc_pkg::CFG_W-1:0]           max_distance,
   input  logic [arsc_pkg::CFG_W-1:0]           min_distance,
   input  logic signed [arsc_pkg::CFG_W-1:0]    default_level,
   output logic                                 active,
   output logic signed [arsc_pkg::LEVEL_W-1:0]  threshold
);
   import arsc_pkg::*;

   logic signed [TRACK_W-1:0]  max_ff, max_in, min_ff, min_in;
   logic signed [TRACK_W-1:0]  level_ext;
   logic signed [TRACK_W:0]    mid_sum, mid_adj, thr_full;
   logic signed [WINDOW_W-1:0] max_w, min_w, def_w, max_dist_w, min_dist_w;
   logic                       invalid;

   assign level_ext = TRACK_W'(level);
   assign max_in    = (level_ext > max_ff) ? level_ext : max_ff;
   assign min_in    = (level_ext < min_ff) ? level_ext : min_ff;

   // Halving rounds toward zero: add one to a negative sum before the shift.
   assign mid_sum  = (TRACK_W + 1)'(max_in) + (TRACK_W + 1)'(min_in);
   assign mid_adj  = mid_sum + $signed({{TRACK_W{1'b0}}, mid_sum[TRACK_W]});
   assign thr_full = mid_adj >>> 1;

   assign max_w      = WINDOW_W'(max_in);
   assign min_w      = WINDOW_W'(min_in);
   assign def_w      = WINDOW_W'(default_level);
   assign max_dist_w = $signed({{(WINDOW_W - CFG_W){1'b0}}, max_distance});
   assign min_dist_w = $signed({{(WINDOW_W - CFG_W){1'b0}}, min_distance});

   assign invalid = (max_w > max_dist_w + def_w) ||
                    ((max_w - min_w) < min_dist_w) ||
                    (min_w < min_dist_w - def_w);

   assign active    = !invalid && ((TRACK_W + 1)'(level) > thr_full);
   assign threshold = thr_full[LEVEL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         max_ff <= TRACK_MAX_RESET;
         min_ff <= TRACK_MIN_RESET;
      end else if (update) begin
         max_ff <= max_in;
         min_ff <= min_in;
      end
   end

   // Once any level has been taken, max can never sit below min.
   a_order: assert property (@(posedge clock) disable iff (reset)
      (max_ff >= min_ff) ||
      (max_ff == TRACK_MAX_RESET && min_ff == TRACK_MIN_RESET))
      else $error("tracker max below min");

endmodule

// ===== design/adaptive_reflect_sensor_classifier.sv =====
// A result appears on rsp_tvalid once the block's last sampling round has passed the input
// register and then the sum, divide and output registers. Throughput: one round or clear
// per cycle unless rsp_tready stalls the pipeline; one result every SAMPLES rounds.
// Reset (synchronous, active high) zeroes the sums and round count, sets the
// trackers to -32760/+32760, and loads the registers with 100, 50, 200, 200.
// Depends on arsc_pkg, arsc_front, arsc_divide and arsc_track.
module adaptive_reflect_sensor_classifier #(
   parameter int SAMPLES = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel: one sampling round or a clear command per transfer.
   input  logic        req_tvalid,
   output logic        req_tready,
   // home_bright[9:0], home_dark[19:10], position_bright[29:20],
   // position_dark[39:30]
   input  logic [39:0] req_tdata,
   // command[0]: round or clear
   input  logic [0:0]  req_tuser,
   // Response channel: one classification per completed block of rounds.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // home_active[0], position_active[1], home_level[12:2],
   // position_level[23:13], home_threshold[34:24],
   // position_threshold[45:35], zero fill[47:46]
   output logic [47:0] rsp_tdata,
   // Register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   import arsc_pkg::*;

   // A block sum of SAMPLES ten-bit differences needs LOG_S extra bits.
   localparam int LOG_S = $clog2(SAMPLES);
   localparam int SUM_W = LEVEL_W + LOG_S;
   localparam int CNT_W = (LOG_S > 0) ? LOG_S : 1;

   logic [CFG_W-1:0]          max_distance_ff, min_distance_ff;
   logic signed [CFG_W-1:0]   home_default_ff, position_default_ff;

   stage_ctl_type             sum_ctl, lvl_ctl;
   logic                      div_ready, out_free, lvl_go;
   logic signed [SUM_W-1:0]   home_total, position_total;
   logic signed [LEVEL_W-1:0] home_level, position_level;
   logic signed [LEVEL_W-1:0] home_thr, position_thr;
   logic                      home_act, position_act;
   logic                      track_update, track_clear;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_home_act_ff, out_position_act_ff;
   logic signed [LEVEL_W-1:0] out_home_level_ff, out_position_level_ff;
   logic signed [LEVEL_W-1:0] out_home_thr_ff, out_position_thr_ff;

   // Configuration writes are always taken; the user must write only while the pipeline
   // is empty, so no item sees a half-updated window. The block does not enforce this.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff     <= CFG_W'(100);
         min_distance_ff     <= CFG_W'(50);
         home_default_ff     <= CFG_W'(200);
         position_default_ff <= CFG_W'(200);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_MAX_DISTANCE:     max_distance_ff     <= csr_data;
            REG_MIN_DISTANCE:     min_distance_ff     <= csr_data;
            REG_HOME_DEFAULT:     home_default_ff     <= csr_data;
            REG_POSITION_DEFAULT: position_default_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Stage 1 and 2: input register and accumulation of dark minus bright.
   arsc_front #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W),
      .CNT_W   (CNT_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .command         (req_tuser[0]),
      .home_bright     (req_tdata[9:0]),
      .home_dark       (req_tdata[19:10]),
      .position_bright (req_tdata[29:20]),
      .position_dark   (req_tdata[39:30]),
      .out_ctl         (sum_ctl),
      .out_ready       (div_ready),
      .home_total      (home_total),
      .position_total  (position_total)
   );

   // Stage 3: block averages.
   arsc_divide #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W)
   ) u_divide (
      .clock          (clock),
      .reset          (reset),
      .in_ctl         (sum_ctl),
      .in_ready       (div_ready),
      .home_total     (home_total),
      .position_total (position_total),
      .out_ctl        (lvl_ctl),
      .out_ready      (out_free),
      .home_level     (home_level),
      .position_level (position_level)
   );

   // Stage 4: the trackers change state as the item moves into the output
   // register. A clear token resets the trackers and leaves no result.
   assign out_free     = !out_valid_ff || rsp_tready;
   assign lvl_go       = lvl_ctl.valid && out_free;
   assign track_update = lvl_go && !lvl_ctl.clear;
   assign track_clear  = lvl_go && lvl_ctl.clear;

   arsc_track u_home (
      .clock         (clock),
      .reset         (reset),
      .update        (track_update),
      .clear         (track_clear),
      .level         (home_level),
      .max_distance  (max_distance_ff),
      .min_distance  (min_distance_ff),
      .default_level (home_default_ff),
      .active        (home_act),
      .threshold     (home_thr)
   );

   arsc_track u_position (
      .clock         (clock),
      .reset         (reset),
      .update        (track_update),
      .clear         (track_clear),
      .level         (position_level),
      .max_distance  (max_distance_ff),
      .min_distance  (min_distance_ff),
      .default_level (position_default_ff),
      .active        (position_act),
      .threshold     (position_thr)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (track_update) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (track_update) begin
         out_home_act_ff       <= home_act;
         out_position_act_ff   <= position_act;
         out_home_level_ff     <= home_level;
         out_position_level_ff <= position_level;
         out_home_thr_ff       <= home_thr;
         out_position_thr_ff   <= position_thr;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00,
                        out_position_thr_ff, out_home_thr_ff,
                        out_position_level_ff, out_home_level_ff,
                        out_position_act_ff, out_home_act_ff};

   // An active sensor is always above its own threshold.
   a_home_above: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_home_act_ff) |-> (out_home_level_ff > out_home_thr_ff))
      else $error("home active without exceeding threshold");

   a_position_above: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_position_act_ff) |->
         (out_position_level_ff > out_position_thr_ff))
      else $error("position active without exceeding threshold");

endmodule

// ===== tb/tb_adaptive_reflect_sensor_classifier.sv =====
// Self-checking testbench for adaptive_reflect_sensor_classifier: a queue-fed request driver,
// a response monitor with a scoreboard, and a predictor of the two-channel classification.
// Depends only on arsc_pkg and the RTL of the block.
module tb_adaptive_reflect_sensor_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   import arsc_pkg::*;

   localparam int SAMPLES        = 8;
   localparam int CLOCK_PERIOD   = 12;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int TRAFFIC_ROUNDS = 180;
   localparam int PHASES         = 5;
   localparam int TIMEOUT_CYCLES = 300000;
   localparam int READING_MAX    = (1 << READING_W) - 1;
   localparam int LEVEL_LIMIT    = (1 << (LEVEL_W - 1)) - 1;
   localparam int CFG_MAX        = (1 << CFG_W) - 1;

   // Request payload, first member in the highest bits so that home_bright lands in [9:0].
   typedef struct packed {
      logic [READING_W-1:0] position_dark;
      logic [READING_W-1:0] position_bright;
      logic [READING_W-1:0] home_dark;
      logic [READING_W-1:0] home_bright;
   } sensor_round_t;

   typedef struct packed {
      logic          command;
      sensor_round_t readings;
   } round_request_t;

   // Response payload laid out exactly like rsp_tdata[45:0].
   typedef struct packed {
      logic signed [LEVEL_W-1:0] position_threshold;
      logic signed [LEVEL_W-1:0] home_threshold;
      logic signed [LEVEL_W-1:0] position_level;
      logic signed [LEVEL_W-1:0] home_level;
      logic                      position_active;
      logic                      home_active;
   } sensor_result_t;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;
   logic [0:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = '0;
   logic [10:0] csr_data    = '0;

   // Traffic shaping knobs, written by the stimulus process between phases.
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic hold_arm       = 1'b0;
   logic rsp_hold       = 1'b0;

   round_request_t round_queue[$];
   sensor_result_t classification_queue[$];
   int             mismatches   = 0;
   int             results_seen = 0;

   // Predictor state: index 0 is the home channel, index 1 the position channel.
   int level_sum [2]     = '{0, 0};
   int rounds_in_block   = 0;
   int track_hi [2]      = '{int'(TRACK_MAX_RESET), int'(TRACK_MAX_RESET)};
   int track_lo [2]      = '{int'(TRACK_MIN_RESET), int'(TRACK_MIN_RESET)};
   int max_dist_cfg      = 100;
   int min_dist_cfg      = 50;
   int level_default [2] = '{200, 200};

   adaptive_reflect_sensor_classifier #(
      .SAMPLES(SAMPLES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard stop in case a handshake never completes or a result never arrives.
   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("** adaptive_reflect_sensor_classifier: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Folds a new level into one channel's running max and min, returns the midpoint
   // through thr and gives the activity bit. The validity window is deliberately the
   // odd one of the original design: the low bound is min_distance minus the default.
   function automatic logic classify_channel(input int ch, input int level, output int thr);
      logic invalid;
      if (level > track_hi[ch]) track_hi[ch] = level;
      if (level < track_lo[ch]) track_lo[ch] = level;
      // SystemVerilog integer division truncates toward zero, as the block must.
      thr = (track_hi[ch] + track_lo[ch]) / 2;
      invalid = (track_hi[ch] > max_dist_cfg + level_default[ch]) ||
                ((track_hi[ch] - track_lo[ch]) < min_dist_cfg) ||
                (track_lo[ch] < min_dist_cfg - level_default[ch]);
      return !invalid && (level > thr);
   endfunction

   // Applies one accepted request to the predictor and queues the classification that
   // the block owes for it, if any.
   function automatic void predict_classification(input logic cmd, input sensor_round_t rd);
      sensor_result_t res;
      int   lvl [2];
      int   thr [2];
      logic act [2];
      if (cmd == CMD_CLEAR) begin
         // A clear only touches the trackers; partial sums and the round count survive.
         for (int c = 0; c < 2; c++) begin
            track_hi[c] = int'(TRACK_MAX_RESET);
            track_lo[c] = int'(TRACK_MIN_RESET);
         end
         return;
      end
      level_sum[0] += int'(rd.home_dark) - int'(rd.home_bright);
      level_sum[1] += int'(rd.position_dark) - int'(rd.position_bright);
      rounds_in_block++;
      if (rounds_in_block < SAMPLES) return;
      rounds_in_block = 0;
      for (int c = 0; c < 2; c++) begin
         lvl[c]       = level_sum[c] / SAMPLES;
         level_sum[c] = 0;
         act[c]       = classify_channel(c, lvl[c], thr[c]);
      end
      res.home_active        = act[0];
      res.position_active    = act[1];
      res.home_level         = LEVEL_W'(lvl[0]);
      res.position_level     = LEVEL_W'(lvl[1]);
      res.home_threshold     = LEVEL_W'(thr[0]);
      res.position_threshold = LEVEL_W'(thr[1]);
      classification_queue.push_back(res);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request driver: pulls items from round_queue and presents them on the request channel.
   // The prediction is made from the bus itself at the edge where the transfer happens.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      logic           offer;
      round_request_t next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_classification(req_tuser[0], sensor_round_t'(req_tdata));
         end
         // A new item may only be put up once the current one has gone across.
         if (!req_tvalid || req_tready) begin
            offer = (round_queue.size() > 0) && (int'($urandom_range(99)) >= send_idle_pct);
            if (offer) begin
               next_item = round_queue.pop_front();
               req_tdata <= next_item.readings;
               req_tuser <= next_item.command;
            end
            req_tvalid <= offer;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Response monitor: every transfer is checked field by field against the oldest
   // prediction. Only the first ten mismatches are printed.
   // ---------------------------------------------------------------------------------------
   function automatic void check_field(input string fname, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("result %0d: %s expected %0d, got %0d", results_seen, fname, want, got);
         end
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      sensor_result_t got;
      sensor_result_t want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = sensor_result_t'(rsp_tdata[$bits(sensor_result_t)-1:0]);
            if (classification_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d arrived with no classification pending: %h",
                           results_seen, rsp_tdata);
               end
            end else begin
               want = classification_queue.pop_front();
               check_field("home_active", int'(want.home_active), int'(got.home_active));
               check_field("position_active", int'(want.position_active),
                           int'(got.position_active));
               check_field("home_level", int'(want.home_level), int'(got.home_level));
               check_field("position_level", int'(want.position_level),
                           int'(got.position_level));
               check_field("home_threshold", int'(want.home_threshold),
                           int'(got.home_threshold));
               check_field("position_threshold", int'(want.position_threshold),
                           int'(got.position_threshold));
            end
            results_seen++;
         end
         rsp_tready <= !rsp_hold && (int'($urandom_range(99)) >= recv_stall_pct);
      end
   end

   // Long receiver hold-off for the pressure phase. It runs in its own process so that
   // the sender keeps offering rounds while the block backs up and drops req_tready.
   initial begin : receiver_hold
      wait (hold_arm);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   function automatic sensor_round_t make_round(input int hb, input int hd,
                                                input int pb, input int pd);
      sensor_round_t rd;
      rd.home_bright     = READING_W'(hb);
      rd.home_dark       = READING_W'(hd);
      rd.position_bright = READING_W'(pb);
      rd.position_dark   = READING_W'(pd);
      return rd;
   endfunction

   function automatic sensor_round_t random_readings();
      return make_round(int'($urandom_range(READING_MAX)), int'($urandom_range(READING_MAX)),
                        int'($urandom_range(READING_MAX)), int'($urandom_range(READING_MAX)));
   endfunction

   function automatic void push_request(input logic cmd, input sensor_round_t rd);
      round_request_t item;
      item.command  = cmd;
      item.readings = rd;
      round_queue.push_back(item);
   endfunction

   // Chooses a bright/dark pair whose dark minus bright equals diff (clamped to the
   // reading range), placed at a random offset so that every reading bit toggles.
   function automatic void split_level(input int diff, output int bright, output int dark);
      int d;
      d = diff;
      if (d > READING_MAX) d = READING_MAX;
      if (d < -READING_MAX) d = -READING_MAX;
      if (d >= 0) begin
         bright = int'($urandom_range(READING_MAX - d));
         dark   = bright + d;
      end else begin
         dark   = int'($urandom_range(READING_MAX + d));
         bright = dark - d;
      end
   endfunction

   function automatic void push_round(input int home_diff, input int position_diff);
      int hb, hd, pb, pd;
      split_level(home_diff, hb, hd);
      split_level(position_diff, pb, pd);
      push_request(CMD_ROUND, make_round(hb, hd, pb, pd));
   endfunction

   // Picks a block level around the channel's current validity window so that both
   // valid and forced-inactive outcomes show up; now and then anywhere in range.
   function automatic int pick_level(input int ch);
      int lo, hi;
      lo = min_dist_cfg - level_default[ch] - 100;
      hi = max_dist_cfg + level_default[ch] + 100;
      if (lo < -LEVEL_LIMIT) lo = -LEVEL_LIMIT;
      if (hi > LEVEL_LIMIT) hi = LEVEL_LIMIT;
      if (hi < lo || $urandom_range(7) == 0) begin
         lo = -LEVEL_LIMIT;
         hi = LEVEL_LIMIT;
      end
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Mostly whole blocks of SAMPLES rounds around chosen levels, mixed with clears
   // (between and inside blocks) and stray rounds with fully random readings.
   function automatic void queue_traffic(input int count);
      int queued;
      int roll;
      int home_target, position_target, amp;
      queued = 0;
      while (queued < count) begin
         roll = int'($urandom_range(99));
         if (roll < 8) begin
            push_request(CMD_CLEAR, random_readings());
            queued++;
         end else if (roll < 18) begin
            push_request(CMD_ROUND, random_readings());
            queued++;
         end else begin
            home_target     = pick_level(0);
            position_target = pick_level(1);
            amp             = int'($urandom_range(40));
            for (int k = 0; k < SAMPLES; k++) begin
               if ($urandom_range(39) == 0) begin
                  push_request(CMD_CLEAR, random_readings());
                  queued++;
               end
               push_round(home_target + int'($urandom_range(2 * amp)) - amp,
                          position_target + int'($urandom_range(2 * amp)) - amp);
               queued++;
            end
         end
      end
   endfunction

   // Register write over the csr channel; the predictor's copy is updated at the transfer.
   task automatic write_register(input csr_index_type idx, input int value);
      logic [CFG_W-1:0] bits;
      bits = CFG_W'(value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= bits;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_MAX_DISTANCE:     max_dist_cfg     = int'(bits);
         REG_MIN_DISTANCE:     min_dist_cfg     = int'(bits);
         REG_HOME_DEFAULT:     level_default[0] = int'($signed(bits));
         REG_POSITION_DEFAULT: level_default[1] = int'($signed(bits));
         default: ;
      endcase
   endtask

   // Waits until every queued item has gone across and every prediction has been met,
   // then lets the pipeline settle so a trailing clear cannot race a register write.
   task automatic wait_drained();
      while (round_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (classification_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      int send_idle_by_phase [PHASES] = '{0, 49, 0, 28, 0};
      int recv_stall_by_phase [PHASES] = '{0, 0, 49, 28, 0};
      int cfg_max, cfg_min, cfg_home, cfg_position;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the registers at their reset values.
      // A clear while the trackers are already at their reset values.
      push_request(CMD_CLEAR, random_readings());
      // Extreme readings: home at the top level, position at the bottom level.
      repeat (SAMPLES) push_request(CMD_ROUND, make_round(0, READING_MAX, READING_MAX, 0));
      // A clear in the middle of a block keeps the partial sums. The home sum ends at -9,
      // so the average must truncate toward zero to -1, not round down to -2.
      repeat (3) push_request(CMD_ROUND, make_round(3, 0, 0, 3));
      push_request(CMD_CLEAR, random_readings());
      repeat (SAMPLES - 3) begin
         push_request(CMD_ROUND, make_round(512, 512, READING_MAX, READING_MAX));
      end
      // Midpoints of -5/2 and +5/2 must truncate toward zero as well, to -2 and +2.
      repeat (SAMPLES) push_request(CMD_ROUND, make_round(1019, 1015, 700, 704));
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               // Window wide open for the position channel; the home low bound sits at 1023.
               cfg_max      = CFG_MAX;
               cfg_min      = 0;
               cfg_home     = -LEVEL_LIMIT;
               cfg_position = LEVEL_LIMIT;
            end
            1: begin
               // Window shut: the required spread cannot be reached.
               cfg_max      = 0;
               cfg_min      = CFG_MAX;
               cfg_home     = LEVEL_LIMIT;
               cfg_position = -LEVEL_LIMIT;
            end
            default: begin
               cfg_max      = 100 + int'($urandom_range(800));
               cfg_min      = int'($urandom_range(200));
               cfg_home     = int'($urandom_range(600)) - 200;
               cfg_position = int'($urandom_range(600)) - 200;
            end
         endcase
         write_register(REG_MAX_DISTANCE, cfg_max);
         write_register(REG_MIN_DISTANCE, cfg_min);
         write_register(REG_HOME_DEFAULT, cfg_home);
         write_register(REG_POSITION_DEFAULT, cfg_position);

         send_idle_pct  <= send_idle_by_phase[phase];
         recv_stall_pct <= recv_stall_by_phase[phase];
         if (phase == PHASES - 1) hold_arm = 1'b1;
         queue_traffic(TRAFFIC_ROUNDS);
         wait_drained();
      end

      if (mismatches == 0 && classification_queue.size() == 0) begin
         $display("** adaptive_reflect_sensor_classifier: PASSED **");
      end else begin
         $display("** adaptive_reflect_sensor_classifier: FAILED **");
      end
      $finish;
   end

endmodule
